>>> design/hrcd_pkg.sv
// Shared constants and helpers for the HTTP response completion detector.
package hrcd_pkg;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_UC_A = 8'h41;
  localparam logic [7:0] CHAR_UC_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  localparam int CHUNK_TAG_LEN = 26;
  localparam int LEN_TAG_LEN   = 15;
  localparam int HDR_END_LEN   = 4;
  localparam int TERM_LEN      = 7;

  localparam logic [7:0] CHUNK_TAG [CHUNK_TAG_LEN] = '{
    "t", "r", "a", "n", "s", "f", "e", "r", "-", "e", "n", "c", "o",
    "d", "i", "n", "g", ":", " ", "c", "h", "u", "n", "k", "e", "d"
  };

  localparam logic [7:0] LEN_TAG [LEN_TAG_LEN] = '{
    "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h", ":"
  };

  localparam logic [7:0] HDR_END [HDR_END_LEN] = '{CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};

  localparam logic [7:0] TERM [TERM_LEN] = '{
    CHAR_CR, CHAR_LF, CHAR_ZERO, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF
  };

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

>>> design/hrcd_length_parser.sv
// Content-length tag matcher and decimal length parser.
module hrcd_length_parser #(
  parameter int LENGTH_BITS = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   clear,
  input  logic                   active,
  input  logic                   hdr_end,
  input  logic [7:0]             data,
  output logic                   valid_next,
  output logic [LENGTH_BITS-1:0] value_cur
);

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_SKIP,
    PH_DIGITS,
    PH_VALID,
    PH_INVALID
  } phase_t;

  phase_t                 phase, phase_c, phase_next;
  logic [3:0]             tag_match, tag_c, tag_match_next;
  logic [LENGTH_BITS-1:0] value, value_next;
  logic [LENGTH_BITS+3:0] scaled;
  logic [3:0]             digit;

  always_comb begin
    tag_c     = clear ? 4'd0 : tag_match;
    phase_c   = clear ? PH_SEARCH : phase;
    value_cur = clear ? '0 : value;
    digit     = data[3:0];
    scaled    = ({4'b0, value_cur} << 3) + ({4'b0, value_cur} << 1)
              + {{LENGTH_BITS{1'b0}}, digit};
    tag_match_next = tag_c;
    phase_next     = phase_c;
    value_next     = value_cur;
    if (active) begin
      case (phase_c)
        PH_SEARCH: begin
          if (data == hrcd_pkg::LEN_TAG[tag_c]) begin
            if (tag_c == 4'(hrcd_pkg::LEN_TAG_LEN - 1)) begin
              tag_match_next = 4'(hrcd_pkg::LEN_TAG_LEN);
              phase_next     = PH_SKIP;
            end else begin
              tag_match_next = tag_c + 4'd1;
            end
          end else if (data == hrcd_pkg::LEN_TAG[0]) begin
            tag_match_next = 4'd1;
          end else begin
            tag_match_next = 4'd0;
          end
        end
        PH_SKIP: begin
          if (!hrcd_pkg::is_ws(data)) begin
            if (hrcd_pkg::is_digit(data)) begin
              value_next = {{(LENGTH_BITS-4){1'b0}}, digit};
              phase_next = PH_DIGITS;
            end else begin
              phase_next = PH_INVALID;
            end
          end
        end
        PH_DIGITS: begin
          if (hrcd_pkg::is_digit(data)) begin
            if (|scaled[LENGTH_BITS+3:LENGTH_BITS]) begin
              phase_next = PH_INVALID;
              value_next = '0;
            end else begin
              value_next = scaled[LENGTH_BITS-1:0];
            end
          end else begin
            phase_next = PH_VALID;
          end
        end
        default: ;
      endcase
      if (hdr_end && (phase_next == PH_SKIP || phase_next == PH_DIGITS)) begin
        phase_next = PH_INVALID;
        value_next = '0;
      end
    end
    valid_next = (phase_next == PH_VALID);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SEARCH;
      tag_match <= 4'd0;
      value     <= '0;
    end else if (step) begin
      phase     <= phase_next;
      tag_match <= tag_match_next;
      value     <= value_next;
    end
  end

endmodule

>>> design/http_response_completion_detector.sv
// Top level of the HTTP response completion detector.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   byte     | byte_valid / byte_ready    | data_byte, first_byte
//   result   | result_valid / result_ready| response_complete, headers_complete,
//            |                            | chunked_mode, length_valid
//
// One byte per cycle: each accepted item updates the matchers and the length
// parser in the accept cycle and its result lands in the output register in the
// next cycle. byte_ready is high while the output register is empty or being
// drained; while a result waits on result_ready no new item is taken.
// rst clears all matcher state; first_byte clears it for the item it rides on.
module http_response_completion_detector #(
  parameter int LENGTH_BITS = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       byte_valid,
  output logic       byte_ready,
  output logic       response_complete,
  output logic       headers_complete,
  output logic       chunked_mode,
  output logic       length_valid,
  output logic       result_valid,
  input  logic       result_ready
);

  logic                   step;
  logic [1:0]             hdr_match, hdr_c, hdr_match_next;
  logic                   header_done, hd_c, header_done_next;
  logic [4:0]             chunk_match, cm_c, chunk_match_next;
  logic                   chunk_seen, cs_c, chunk_seen_next;
  logic [2:0]             term_match, tm_c, term_match_next;
  logic [LENGTH_BITS-1:0] body_count, body_c, body_count_next;
  logic                   done_flag, done_c, done_flag_next;
  logic                   hdr_end;
  logic                   complete;
  logic [7:0]             folded;
  logic                   len_valid_next;
  logic [LENGTH_BITS-1:0] len_value;

  assign byte_ready = !result_valid || result_ready;
  assign step       = byte_valid && byte_ready;

  always_comb begin
    hdr_c  = first_byte ? 2'd0 : hdr_match;
    hd_c   = first_byte ? 1'b0 : header_done;
    cm_c   = first_byte ? 5'd0 : chunk_match;
    cs_c   = first_byte ? 1'b0 : chunk_seen;
    tm_c   = first_byte ? 3'd0 : term_match;
    body_c = first_byte ? '0 : body_count;
    done_c = first_byte ? 1'b0 : done_flag;

    folded = (data_byte >= hrcd_pkg::CHAR_UC_A && data_byte <= hrcd_pkg::CHAR_UC_Z)
           ? (data_byte | hrcd_pkg::CASE_BIT) : data_byte;

    hdr_match_next   = hdr_c;
    header_done_next = hd_c;
    chunk_match_next = cm_c;
    chunk_seen_next  = cs_c;
    term_match_next  = tm_c;
    body_count_next  = body_c;
    hdr_end          = 1'b0;

    if (!hd_c) begin
      if (!cs_c) begin
        if (folded == hrcd_pkg::CHUNK_TAG[cm_c]) begin
          if (cm_c == 5'(hrcd_pkg::CHUNK_TAG_LEN - 1)) begin
            chunk_seen_next  = 1'b1;
            chunk_match_next = 5'd0;
          end else begin
            chunk_match_next = cm_c + 5'd1;
          end
        end else if (folded == hrcd_pkg::CHUNK_TAG[0]) begin
          chunk_match_next = 5'd1;
        end else begin
          chunk_match_next = 5'd0;
        end
      end
      if (data_byte == hrcd_pkg::HDR_END[hdr_c]) begin
        if (hdr_c == 2'(hrcd_pkg::HDR_END_LEN - 1)) begin
          hdr_match_next   = 2'd0;
          header_done_next = 1'b1;
          hdr_end          = 1'b1;
        end else begin
          hdr_match_next = hdr_c + 2'd1;
        end
      end else if (data_byte == hrcd_pkg::CHAR_CR) begin
        hdr_match_next = 2'd1;
      end else begin
        hdr_match_next = 2'd0;
      end
    end else begin
      body_count_next = (&body_c) ? body_c : body_c + 1'b1;
      if (cs_c && tm_c != 3'(hrcd_pkg::TERM_LEN)) begin
        if (data_byte == hrcd_pkg::TERM[tm_c]) begin
          term_match_next = tm_c + 3'd1;
        end else if (tm_c == 3'd5 && data_byte == hrcd_pkg::CHAR_ZERO) begin
          // after CR LF 0 CR LF a '0' restarts from CR LF 0
          term_match_next = 3'd3;
        end else if (data_byte == hrcd_pkg::CHAR_CR) begin
          term_match_next = 3'd1;
        end else begin
          term_match_next = 3'd0;
        end
      end
    end
  end

  assign complete = header_done_next &&
                    (chunk_seen_next ? (term_match_next == 3'(hrcd_pkg::TERM_LEN))
                                     : (len_valid_next && body_count_next >= len_value));
  assign done_flag_next = done_c || complete;

  hrcd_length_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_length_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .clear      (first_byte),
    .active     (!hd_c),
    .hdr_end    (hdr_end),
    .data       (folded),
    .valid_next (len_valid_next),
    .value_cur  (len_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_match    <= 2'd0;
      header_done  <= 1'b0;
      chunk_match  <= 5'd0;
      chunk_seen   <= 1'b0;
      term_match   <= 3'd0;
      body_count   <= '0;
      done_flag    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (step) begin
        hdr_match    <= hdr_match_next;
        header_done  <= header_done_next;
        chunk_match  <= chunk_match_next;
        chunk_seen   <= chunk_seen_next;
        term_match   <= term_match_next;
        body_count   <= body_count_next;
        done_flag    <= done_flag_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      response_complete <= done_flag_next;
      headers_complete  <= header_done_next;
      chunked_mode      <= chunk_seen_next;
      length_valid      <= len_valid_next;
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the HTTP response completion detector: random HTTP traffic in.
module tb;

  localparam int LENGTH_BITS = 40;
  localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS) - 64'd1;
  localparam int NUM_BYTES = 850;
  localparam int IDLE_LIMIT = 1000;

  typedef enum logic [2:0] {
    LP_SEARCH, LP_SKIP, LP_DIGITS, LP_VALID, LP_INVALID
  } len_phase_t;

  typedef enum logic [1:0] {PAT_CHUNK, PAT_LEN, PAT_HDR, PAT_TERM} pattern_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } byte_item_t;

  typedef struct packed {
    logic complete;
    logic hdrs;
    logic chunked;
    logic len_ok;
  } status_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] data_byte = 8'h00;
  logic       first_byte = 1'b0;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  logic       response_complete;
  logic       headers_complete;
  logic       chunked_mode;
  logic       length_valid;
  logic       result_valid;
  logic       result_ready = 1'b0;

  byte_item_t pend_bytes[$];
  status_t    exp_status[$];
  int         errors = 0;
  logic       new_resp = 1'b0;

  // tracking copy of the detector state
  int          hdr_m = 0;
  int          chunk_m = 0;
  int          len_m = 0;
  int          term_m = 0;
  logic        hdr_seen = 1'b0;
  logic        chunk_seen = 1'b0;
  logic        resp_done = 1'b0;
  len_phase_t  lphase = LP_SEARCH;
  logic [63:0] clen = 64'd0;
  logic [63:0] body_cnt = 64'd0;

  http_response_completion_detector #(.LENGTH_BITS(LENGTH_BITS)) u_top (
    .clk              (clk),
    .rst              (rst),
    .data_byte        (data_byte),
    .first_byte       (first_byte),
    .byte_valid       (byte_valid),
    .byte_ready       (byte_ready),
    .response_complete(response_complete),
    .headers_complete (headers_complete),
    .chunked_mode     (chunked_mode),
    .length_valid     (length_valid),
    .result_valid     (result_valid),
    .result_ready     (result_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] pat_byte(pattern_t p, int i);
    case (p)
      PAT_CHUNK: return hrcd_pkg::CHUNK_TAG[i];
      PAT_LEN:   return hrcd_pkg::LEN_TAG[i];
      PAT_HDR:   return hrcd_pkg::HDR_END[i];
      default:   return hrcd_pkg::TERM[i];
    endcase
  endfunction

  function automatic int pat_len(pattern_t p);
    case (p)
      PAT_CHUNK: return hrcd_pkg::CHUNK_TAG_LEN;
      PAT_LEN:   return hrcd_pkg::LEN_TAG_LEN;
      PAT_HDR:   return hrcd_pkg::HDR_END_LEN;
      default:   return hrcd_pkg::TERM_LEN;
    endcase
  endfunction

  // longest prefix of the pattern that ends the matched text plus c
  function automatic int pat_next(pattern_t p, int j, logic [7:0] c);
    int   k;
    int   i;
    int   off;
    logic ok;
    if (j >= pat_len(p)) j = 0;
    for (k = j + 1; k > 0; k--) begin
      off = j + 1 - k;
      ok = (pat_byte(p, k - 1) == c);
      for (i = 0; ok && i + 1 < k; i++)
        if (pat_byte(p, i) != pat_byte(p, off + i)) ok = 1'b0;
      if (ok) return k;
    end
    return 0;
  endfunction

  task automatic track_byte(input logic [7:0] c, input logic first, output status_t st);
    logic [7:0]  f;
    logic [63:0] d;
    logic        hit;
    if (first) begin
      hdr_m = 0;
      chunk_m = 0;
      len_m = 0;
      term_m = 0;
      hdr_seen = 1'b0;
      chunk_seen = 1'b0;
      resp_done = 1'b0;
      lphase = LP_SEARCH;
      clen = 64'd0;
      body_cnt = 64'd0;
    end
    if (!hdr_seen) begin
      f = (c >= hrcd_pkg::CHAR_UC_A && c <= hrcd_pkg::CHAR_UC_Z)
        ? (c | hrcd_pkg::CASE_BIT) : c;
      if (!chunk_seen) begin
        chunk_m = pat_next(PAT_CHUNK, chunk_m, f);
        if (chunk_m >= hrcd_pkg::CHUNK_TAG_LEN) begin
          chunk_seen = 1'b1;
          chunk_m = 0;
        end
      end
      case (lphase)
        LP_SEARCH: begin
          len_m = pat_next(PAT_LEN, len_m, f);
          if (len_m >= hrcd_pkg::LEN_TAG_LEN) begin
            len_m = hrcd_pkg::LEN_TAG_LEN;
            lphase = LP_SKIP;
          end
        end
        LP_SKIP: begin
          if (!(f == 8'h20 || (f >= 8'h09 && f <= 8'h0D))) begin
            if (f >= hrcd_pkg::CHAR_ZERO && f <= hrcd_pkg::CHAR_NINE) begin
              clen = {56'd0, f - hrcd_pkg::CHAR_ZERO};
              lphase = LP_DIGITS;
            end else begin
              lphase = LP_INVALID;
            end
          end
        end
        LP_DIGITS: begin
          if (f >= hrcd_pkg::CHAR_ZERO && f <= hrcd_pkg::CHAR_NINE) begin
            d = {56'd0, f - hrcd_pkg::CHAR_ZERO};
            if (clen > (LEN_MAX - d) / 64'd10) begin
              lphase = LP_INVALID;
              clen = 64'd0;
            end else begin
              clen = clen * 64'd10 + d;
            end
          end else begin
            lphase = LP_VALID;
          end
        end
        default: ;
      endcase
      hdr_m = pat_next(PAT_HDR, hdr_m, c);
      if (hdr_m >= hrcd_pkg::HDR_END_LEN) begin
        hdr_m = 0;
        hdr_seen = 1'b1;
        if (lphase == LP_SKIP || lphase == LP_DIGITS) begin
          lphase = LP_INVALID;
          clen = 64'd0;
        end
      end
    end else begin
      if (body_cnt < LEN_MAX) body_cnt = body_cnt + 64'd1;
      if (chunk_seen && term_m < hrcd_pkg::TERM_LEN) term_m = pat_next(PAT_TERM, term_m, c);
    end
    hit = 1'b0;
    if (hdr_seen)
      hit = chunk_seen ? (term_m >= hrcd_pkg::TERM_LEN)
                       : (lphase == LP_VALID && body_cnt >= clen);
    if (hit) resp_done = 1'b1;
    st = '{resp_done, hdr_seen, chunk_seen, lphase == LP_VALID};
  endtask

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic push_byte(input logic [7:0] c);
    pend_bytes.push_back('{c, new_resp});
    new_resp = 1'b0;
  endtask

  // mix: letters get random case
  task automatic push_text(input string s, input logic mix);
    int         i;
    logic [7:0] ch;
    for (i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (mix && ((ch | hrcd_pkg::CASE_BIT) >= (hrcd_pkg::CHAR_UC_A | hrcd_pkg::CASE_BIT)) &&
          ((ch | hrcd_pkg::CASE_BIT) <= (hrcd_pkg::CHAR_UC_Z | hrcd_pkg::CASE_BIT)) &&
          $urandom_range(0, 1))
        ch = ch ^ hrcd_pkg::CASE_BIT;
      push_byte(ch);
    end
  endtask

  task automatic gen_response();
    int         kind;
    int         lmode;
    int         n;
    int         i;
    int         j;
    int         blen;
    int         clen_v;
    logic       chunked;
    logic       te_late;
    logic [7:0] ws;
    new_resp = 1'b1;
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      n = $urandom_range(1, 24);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0)
          push_byte($urandom_range(0, 1) ? hrcd_pkg::CHAR_CR : hrcd_pkg::CHAR_LF);
        else push_byte(8'($urandom_range(0, 255)));
      end
      return;
    end
    if ($urandom_range(0, 3) == 0) push_text("HTTP/1.1 200 OK\r\n", 1'b0);
    chunked = ($urandom_range(0, 2) == 0);
    te_late = 1'($urandom_range(0, 1));
    // 0 none, 1-4 plain, 5 no digits, 6 non-digit, 7 overflow, 8 max, 9 leading zeros
    lmode = $urandom_range(0, 9);
    clen_v = $urandom_range(0, 24);
    if ($urandom_range(0, 2) == 0) push_text("Host: a\r\n", 1'b1);
    if (chunked && !te_late) push_text("Transfer-Encoding: chunked\r\n", 1'b1);
    if (lmode != 0) begin
      push_text("Content-Length:", 1'b1);
      n = $urandom_range(0, 2);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: ws = 8'h09;
          1: ws = 8'h0B;
          2: ws = 8'h0C;
          default: ws = 8'h20;
        endcase
        push_byte(ws);
      end
      case (lmode)
        5: ;
        6: push_text("x1", 1'b0);
        7: begin
          if ($urandom_range(0, 1)) push_text("1099511627776", 1'b0);
          else push_text("99999999999999", 1'b0);
        end
        8: push_text("1099511627775", 1'b0);
        9: push_text($sformatf("000%0d", clen_v), 1'b0);
        default: push_text($sformatf("%0d", clen_v), 1'b0);
      endcase
      push_text("\r\n", 1'b0);
      if ($urandom_range(0, 3) == 0) push_text("content-length: 3\r\n", 1'b1);
    end
    if (chunked && te_late) push_text("Transfer-Encoding: chunked\r\n", 1'b1);
    if ($urandom_range(0, 9) == 0) return;
    push_text("\r\n", 1'b0);
    if (chunked) begin
      // a bare last chunk right after the headers lacks the leading CRLF
      if ($urandom_range(0, 3) == 0) push_text("0\r\n\r\n", 1'b0);
      n = $urandom_range(0, 2);
      for (i = 0; i < n; i++) begin
        blen = $urandom_range(1, 9);
        push_text($sformatf("%0x\r\n", blen), 1'b0);
        for (j = 0; j < blen; j++) push_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 7) != 0) push_text("\r\n0\r\n\r\n", 1'b0);
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
    end else begin
      if ((lmode >= 1 && lmode <= 4) || lmode == 9) begin
        blen = clen_v + $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) blen = (clen_v > 0) ? clen_v - 1 : 0;
      end else begin
        blen = $urandom_range(0, 6);
      end
      for (i = 0; i < blen; i++) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // sender: bursts of items with gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drv
    status_t st;
    logic    hold;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) begin
        track_byte(data_byte, first_byte, st);
        exp_status.push_back(st);
        void'(pend_bytes.pop_front());
      end
      hold = byte_valid && !byte_ready;
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_valid <= 1'b0;
        end else if (pend_bytes.size() > 0) begin
          byte_valid <= 1'b1;
          data_byte <= pend_bytes[0].data;
          first_byte <= pend_bytes[0].first;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, renewed now and then
  logic [15:0] rdy_pat = 16'hFFFF;
  int          rdy_left = 0;

  always @(posedge clk) begin : rcv
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_left = $urandom_range(8, 64);
        rdy_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end else begin
        rdy_left--;
        rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
      end
      result_ready <= rdy_pat[0];
    end
  end

  always @(posedge clk) begin : mon
    status_t want;
    if (!rst && result_valid && result_ready) begin
      if (exp_status.size() == 0) begin
        report("result with no item pending");
      end else begin
        want = exp_status.pop_front();
        if (response_complete !== want.complete)
          report($sformatf("response_complete got %b want %b", response_complete,
                           want.complete));
        if (headers_complete !== want.hdrs)
          report($sformatf("headers_complete got %b want %b", headers_complete, want.hdrs));
        if (chunked_mode !== want.chunked)
          report($sformatf("chunked_mode got %b want %b", chunked_mode, want.chunked));
        if (length_valid !== want.len_ok)
          report($sformatf("length_valid got %b want %b", length_valid, want.len_ok));
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[http_response_completion_detector] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // directed: bare header end, byte extremes, zero length then a trailing byte
    new_resp = 1'b1;
    push_text("\r\n\r\n", 1'b0);
    new_resp = 1'b1;
    push_byte(8'h00);
    push_byte(8'hFF);
    new_resp = 1'b1;
    push_text("Content-Length: 0\r\n\r\nx", 1'b1);
    while (pend_bytes.size() < NUM_BYTES) gen_response();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (pend_bytes.size() != 0 || exp_status.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("[http_response_completion_detector] OK");
    end else begin
      $display("[http_response_completion_detector] ERROR");
    end
    $finish;
  end

endmodule

>>> http_response_completion_detector.f
design/hrcd_pkg.sv
design/hrcd_length_parser.sv
design/http_response_completion_detector.sv
verif/tb.sv
